/* rtl/core/vlpd_pkg.sv */
// Shared types and constants for the varint length-prefix deframer.
`timescale 1ns / 1ps

package vlpd_pkg;

    // Byte field constants
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned KIND_W   = 2;

    // Result kinds carried on tuser
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Reset value of the max_length register
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'h7FFF_FFFF;

    // Framing phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_HALTED  = 3'b100
    } phase_t;

    // One result item as produced by the step logic
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              last;
    } result_t;

endpackage

/* rtl/core/varint_length_prefix_deframer.sv */
// Top level: varint length-prefix deframer with stream ports and output register.
// Output: each result is registered and appears on the m_ side in the cycle after the byte that causes it.
// Throughput: one stream byte per cycle; s_tready stays high while the output
// register is empty or being taken in the same cycle.
// Reset: synchronous, active low; header phase, max_length = 0x7FFFFFFF, no result held.
`timescale 1ns / 1ps

module varint_length_prefix_deframer #(
    parameter int unsigned MAX_PREFIX_BYTES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: max_length
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast     // last
);

    localparam int unsigned GI_W  = $clog2(MAX_PREFIX_BYTES + 1);
    localparam int unsigned ACC_W = vlpd_pkg::GROUP_W * MAX_PREFIX_BYTES;

    logic [vlpd_pkg::LEN_W-1:0] max_length_reg;
    vlpd_pkg::phase_t           phase_reg, phase_next;
    logic [GI_W-1:0]            group_reg, group_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [vlpd_pkg::LEN_W-1:0] rem_reg, rem_next;
    vlpd_pkg::result_t          step_res;

    logic                       out_valid_reg;
    logic [7:0]                 out_data_reg;
    logic [1:0]                 out_kind_reg;
    logic                       out_last_reg;
    logic                       in_xfer;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Per-byte framing logic
    vlpd_step #(
        .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
    ) u_step (
        .in_byte         (s_tdata),
        .max_length      (max_length_reg),
        .phase           (phase_reg),
        .group_index     (group_reg),
        .length_acc      (acc_reg),
        .bytes_rem       (rem_reg),
        .phase_next      (phase_next),
        .group_index_next(group_next),
        .length_acc_next (acc_next),
        .bytes_rem_next  (rem_next),
        .result          (step_res)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= vlpd_pkg::MAX_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            max_length_reg <= cfg_wr_data;
        end
    end

    // Framing state, advanced on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= vlpd_pkg::PH_HEADER;
            group_reg <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
        end else if (in_xfer) begin
            phase_reg <= phase_next;
            group_reg <= group_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            out_valid_reg <= step_res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (in_xfer && step_res.valid) begin
            out_data_reg <= step_res.data;
            out_kind_reg <= step_res.kind;
            out_last_reg <= step_res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Once halted, the block stays halted until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == vlpd_pkg::PH_HALTED |=> phase_reg == vlpd_pkg::PH_HALTED)
        else $error("deframer left halted phase without reset");

    // An error result always halts the block
    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && step_res.valid && step_res.kind == vlpd_pkg::KIND_ERROR
        |=> phase_reg == vlpd_pkg::PH_HALTED)
        else $error("error result without halt");

    // Payload phase always has bytes still due
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == vlpd_pkg::PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // A held result is not overwritten while stalled
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg)
        && $stable(out_kind_reg) && $stable(out_last_reg))
        else $error("stalled result was lost");

endmodule

/* rtl/core/vlpd_step.sv */
// Next-state and result logic for one stream byte of the deframer.
`timescale 1ns / 1ps

module vlpd_step #(
    parameter int unsigned MAX_PREFIX_BYTES = 5
) (
    input  logic [vlpd_pkg::BYTE_W-1:0]                    in_byte,
    input  logic [vlpd_pkg::LEN_W-1:0]                     max_length,
    input  vlpd_pkg::phase_t                               phase,
    input  logic [$clog2(MAX_PREFIX_BYTES+1)-1:0]          group_index,
    input  logic [vlpd_pkg::GROUP_W*MAX_PREFIX_BYTES-1:0]  length_acc,
    input  logic [vlpd_pkg::LEN_W-1:0]                     bytes_rem,
    output vlpd_pkg::phase_t                               phase_next,
    output logic [$clog2(MAX_PREFIX_BYTES+1)-1:0]          group_index_next,
    output logic [vlpd_pkg::GROUP_W*MAX_PREFIX_BYTES-1:0]  length_acc_next,
    output logic [vlpd_pkg::LEN_W-1:0]                     bytes_rem_next,
    output vlpd_pkg::result_t                              result
);

    localparam int unsigned GI_W  = $clog2(MAX_PREFIX_BYTES + 1);
    localparam int unsigned ACC_W = vlpd_pkg::GROUP_W * MAX_PREFIX_BYTES;
    localparam int unsigned CMP_W = (ACC_W > vlpd_pkg::LEN_W) ? ACC_W : vlpd_pkg::LEN_W;
    localparam logic [GI_W-1:0] GI_LAST = GI_W'(MAX_PREFIX_BYTES - 1);

    logic [ACC_W-1:0] acc_merged;
    logic [CMP_W-1:0] len_cmp;
    logic             too_big;
    logic             more;
    logic             fin;

    // Place the new 7-bit group at its position in the length
    assign acc_merged = length_acc
        | (ACC_W'(in_byte[vlpd_pkg::GROUP_W-1:0]) << (vlpd_pkg::GROUP_W * group_index));
    assign len_cmp    = CMP_W'(acc_merged);
    assign too_big    = len_cmp > CMP_W'(max_length);
    assign more       = in_byte[vlpd_pkg::BYTE_W-1];
    assign fin        = (bytes_rem[vlpd_pkg::LEN_W-1:1] == '0);

    always_comb begin
        phase_next       = phase;
        group_index_next = group_index;
        length_acc_next  = length_acc;
        bytes_rem_next   = bytes_rem;
        result           = '0;
        case (phase)
            vlpd_pkg::PH_PAYLOAD: begin
                // Pass the byte through, mark the final one
                result.valid = 1'b1;
                result.data  = in_byte;
                result.kind  = vlpd_pkg::KIND_DATA;
                result.last  = fin;
                if (fin) begin
                    bytes_rem_next = '0;
                    phase_next     = vlpd_pkg::PH_HEADER;
                end else begin
                    bytes_rem_next = bytes_rem - 1'b1;
                end
            end
            vlpd_pkg::PH_HEADER: begin
                if (more) begin
                    if (group_index == GI_LAST) begin
                        // Header runs past its longest form
                        phase_next       = vlpd_pkg::PH_HALTED;
                        group_index_next = '0;
                        length_acc_next  = '0;
                        bytes_rem_next   = '0;
                        result.valid     = 1'b1;
                        result.kind      = vlpd_pkg::KIND_ERROR;
                    end else begin
                        group_index_next = group_index + 1'b1;
                        length_acc_next  = acc_merged;
                    end
                end else begin
                    // Header complete
                    group_index_next = '0;
                    length_acc_next  = '0;
                    if (too_big) begin
                        phase_next   = vlpd_pkg::PH_HALTED;
                        result.valid = 1'b1;
                        result.kind  = vlpd_pkg::KIND_ERROR;
                    end else if (len_cmp == '0) begin
                        result.valid = 1'b1;
                        result.kind  = vlpd_pkg::KIND_EMPTY;
                        result.last  = 1'b1;
                    end else begin
                        bytes_rem_next = vlpd_pkg::LEN_W'(acc_merged);
                        phase_next     = vlpd_pkg::PH_PAYLOAD;
                    end
                end
            end
            default: begin
                // Halted: bytes are dropped
            end
        endcase
    end

endmodule

/* tb/varint_length_prefix_deframer_test.sv */
// Self-checking testbench for the varint length-prefix deframer stream block.
`timescale 1ns / 1ps

module varint_length_prefix_deframer_test;

    localparam int unsigned PREFIX_BYTES = 5;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_CYCLES = 4;

    // Final framing fault; only one per run, since it halts the block until reset
    typedef enum int {
        FAULT_LONG_HEADER,
        FAULT_OVER_MAX,
        FAULT_WIDE_LENGTH
    } fault_t;

    // One deframed output transfer
    typedef struct {
        logic [7:0]                  data;
        logic [vlpd_pkg::KIND_W-1:0] kind;
        logic                        last;
    } deframed_t;

    // Tracks framing state and the deframed transfers still due from the DUT
    class deframe_scoreboard;
        vlpd_pkg::phase_t phase;
        int unsigned      group_index;
        logic [34:0]      length_acc;
        logic [31:0]      bytes_left;
        logic [31:0]      max_length;
        deframed_t        due_results[$];
        int unsigned      mismatches;

        function new();
            phase       = vlpd_pkg::PH_HEADER;
            group_index = 0;
            length_acc  = '0;
            bytes_left  = '0;
            max_length  = vlpd_pkg::MAX_LENGTH_RESET;
            mismatches  = 0;
        endfunction

        function void set_max_length(logic [31:0] value);
            max_length = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void push_result(logic [7:0] d, logic [vlpd_pkg::KIND_W-1:0] k, logic l);
            deframed_t r;
            r.data = d;
            r.kind = k;
            r.last = l;
            due_results.push_back(r);
        endfunction

        function void halt_on_fault();
            phase       = vlpd_pkg::PH_HALTED;
            group_index = 0;
            length_acc  = '0;
            bytes_left  = '0;
            push_result(8'h00, vlpd_pkg::KIND_ERROR, 1'b0);
        endfunction

        // Advance framing state by one accepted input byte
        function void deframe_byte(logic [7:0] value);
            logic        fin;
            logic [34:0] msg_len;
            case (phase)
                vlpd_pkg::PH_PAYLOAD: begin
                    fin = (bytes_left <= 32'd1);
                    if (bytes_left > 0) bytes_left = bytes_left - 32'd1;
                    if (fin) begin
                        bytes_left = '0;
                        phase      = vlpd_pkg::PH_HEADER;
                    end
                    push_result(value, vlpd_pkg::KIND_DATA, fin);
                end
                vlpd_pkg::PH_HEADER: begin
                    if (group_index >= PREFIX_BYTES) begin
                        halt_on_fault();
                    end else begin
                        length_acc  = length_acc | (35'(value[6:0]) << (7 * group_index));
                        group_index = group_index + 1;
                        if (value[7]) begin
                            // header still running; too long once the limit is hit
                            if (group_index >= PREFIX_BYTES) halt_on_fault();
                        end else begin
                            msg_len     = length_acc;
                            length_acc  = '0;
                            group_index = 0;
                            if (msg_len > {3'b000, max_length}) begin
                                halt_on_fault();
                            end else if (msg_len == 0) begin
                                push_result(8'h00, vlpd_pkg::KIND_EMPTY, 1'b1);
                            end else begin
                                bytes_left = msg_len[31:0];
                                phase      = vlpd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                default: begin
                    // halted: byte is dropped
                end
            endcase
        endfunction

        // Compare one output transfer with the oldest one due
        function void check_result(logic [7:0] d, logic [vlpd_pkg::KIND_W-1:0] k, logic l);
            deframed_t exp_r;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer data=%02h kind=%0d last=%0b",
                         $time, d, k, l);
                return;
            end
            exp_r = due_results.pop_front();
            if (d !== exp_r.data) begin
                mismatches++;
                $display("%0t: data mismatch expected %02h actual %02h",
                         $time, exp_r.data, d);
            end
            if (k !== exp_r.kind) begin
                mismatches++;
                $display("%0t: kind mismatch expected %0d actual %0d",
                         $time, exp_r.kind, k);
            end
            if (l !== exp_r.last) begin
                mismatches++;
                $display("%0t: last mismatch expected %0b actual %0b",
                         $time, exp_r.last, l);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    deframe_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned cycles         = 0;
    logic [31:0] max_len_now    = vlpd_pkg::MAX_LENGTH_RESET;

    varint_length_prefix_deframer #(
        .MAX_PREFIX_BYTES (PREFIX_BYTES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitors: check outputs before noting this edge's input
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
        if (aresetn && s_tvalid && s_tready) sb.deframe_byte(s_tdata);
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] value, input bit counted);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (counted) items_sent++;
    endtask

    // Varint header, optionally padded with zero groups, then the payload
    task automatic send_message(input int unsigned len, input bit pad);
        logic [6:0]  groups[$];
        logic [34:0] rest;
        int unsigned extra;
        rest = 35'(len);
        do begin
            groups.push_back(rest[6:0]);
            rest = rest >> 7;
        end while (rest != 0);
        extra = pad ? $urandom_range(PREFIX_BYTES - groups.size()) : 0;
        repeat (extra) groups.push_back(7'h00);
        foreach (groups[i]) send_byte({(i < groups.size() - 1), groups[i]}, 1'b1);
        repeat (len) send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // Mostly short messages, some spanning two header groups
    function automatic int unsigned pick_length();
        int unsigned roll;
        longint unsigned len;
        roll = $urandom_range(99);
        if (roll < 70) len = $urandom_range(8);
        else if (roll < 95) len = $urandom_range(40, 9);
        else len = $urandom_range(300, 100);
        if (max_len_now < 64 && $urandom_range(4) == 0) len = max_len_now;
        if (len > max_len_now) len = max_len_now;
        return int'(len);
    endfunction

    // Hold the sender until every due transfer has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_max_length(value);
        max_len_now = value;
        @(posedge aclk);
    endtask

    task automatic run_random(input int unsigned item_goal);
        while (items_sent < item_goal) send_message(pick_length(), ($urandom_range(3) == 0));
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Closing framing fault, then bytes the halted block must drop
    task automatic send_fault();
        fault_t      fault;
        int unsigned limit;
        fault = fault_t'($urandom_range(2));
        case (fault)
            FAULT_LONG_HEADER: begin
                repeat (PREFIX_BYTES) send_byte(8'h80 | 8'($urandom_range(127)), 1'b1);
            end
            FAULT_OVER_MAX: begin
                limit = $urandom_range(30);
                write_max_length(32'(limit));
                send_byte(8'(limit + 1), 1'b1);
            end
            default: begin
                // length needs more than 32 bits even against the widest limit
                write_max_length(32'hFFFF_FFFF);
                repeat (PREFIX_BYTES - 1) send_byte(8'h80 | 8'($urandom_range(127)), 1'b1);
                send_byte(8'($urandom_range(127, 16)), 1'b1);
            end
        endcase
        repeat (8) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty messages, padded headers, payload extremes
        set_idling(0, 0);
        send_byte(8'h00, 1'b1);
        repeat (PREFIX_BYTES - 1) send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h82, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h83, 1'b1);
        repeat (PREFIX_BYTES - 2) send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b1);

        // Random phases, each with its own limit and idling mix
        run_random(300);
        drain();
        write_max_length(32'hFFFF_FFFF);
        set_idling(71, 0);
        run_random(700);
        drain();
        write_max_length(32'h0000_0000);
        set_idling(0, 71);
        run_random(850);
        drain();
        write_max_length(32'($urandom_range(20, 1)));
        set_idling(23, 23);
        run_random(1200);
        drain();
        write_max_length($urandom());
        set_idling(0, 0);
        run_random(1500);
        drain();
        write_max_length(32'h0000_0001);
        set_idling(71, 0);
        run_random(1800);
        drain();

        set_idling(23, 23);
        send_fault();
        drain();
        repeat (10) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/vlpd_pkg.sv
rtl/core/vlpd_step.sv
rtl/core/varint_length_prefix_deframer.sv
tb/varint_length_prefix_deframer_test.sv
